@@ rtl/sfr_pkg.sv @@
package sfr_pkg;

   localparam int ANGLE_W = 32;
   localparam int VEC_FRAC = 30;
   localparam int ROT_STEPS = 30;
   localparam int STEP_W = 5;
   localparam int VW = 36;
   localparam int AW = 36;
   localparam int PW = 64;
   localparam int SW = 66;
   localparam int MW = 72;

   localparam logic [1:0] OP_EQ_TO_GAL = 2'd0;
   localparam logic [1:0] OP_GAL_TO_EQ = 2'd1;
   localparam logic [1:0] OP_GAL_TO_SG = 2'd2;
   localparam logic [1:0] OP_SG_TO_GAL = 2'd3;

   localparam logic signed [VW-1:0] GAIN = 36'sd652032874;
   localparam logic signed [VW-1:0] ONE_V = 36'sd1073741824;
   localparam logic signed [AW-1:0] QUARTER = 36'sd1073741824;
   localparam logic signed [AW-1:0] HALF = 36'sd2147483648;
   localparam logic signed [SW-1:0] ROUND_BIAS = 66'sd536870912;
   localparam longint DEN = 244140625;

   typedef logic signed [31:0] q30_type;
   localparam q30_type ONE_Q = 32'sd1073741824;

   typedef struct packed {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [AW-1:0] z;
   } cordic_type;

   // Arctangent of 2^-i in units of 2^-32 turn, rounded to nearest.
   localparam logic signed [AW-1:0] ARC_TAB [ROT_STEPS] = '{
      36'sd536870912, 36'sd316933406, 36'sd167458907, 36'sd85004756,
      36'sd42667331,  36'sd21354465,  36'sd10679838,  36'sd5340245,
      36'sd2670163,   36'sd1335087,   36'sd667544,    36'sd333772,
      36'sd166886,    36'sd83443,     36'sd41722,     36'sd20861,
      36'sd10430,     36'sd5215,      36'sd2608,      36'sd1304,
      36'sd652,       36'sd326,       36'sd163,       36'sd81,
      36'sd41,        36'sd20,        36'sd10,        36'sd5,
      36'sd3,         36'sd1};

   // Converts a coefficient given in units of 1e-12 to Q1.30, rounded.
   function automatic q30_type q30_of(input longint c);
      longint mag;
      longint q;
      mag = (c < 0) ? -c : c;
      q = (mag * 262144 + 122070312) / DEN;
      return (c < 0) ? 32'(-q) : 32'(q);
   endfunction

   // Row-major matrices: equatorial to galactic, then galactic to supergalactic.
   localparam q30_type FRAME_Q [18] = '{
      q30_of(-64'sd54875539726),  q30_of(-64'sd873437108010), q30_of(-64'sd483834985808),
      q30_of(64'sd494109453312),  q30_of(-64'sd444829589425), q30_of(64'sd746982251810),
      q30_of(-64'sd867666135858), q30_of(-64'sd198076386122), q30_of(64'sd455983795705),
      q30_of(-64'sd735742574804), q30_of(64'sd677261296414),  q30_of(64'sd0),
      q30_of(-64'sd74553778365),  q30_of(-64'sd80991471307),  q30_of(64'sd993922590400),
      q30_of(64'sd673145302109),  q30_of(64'sd731271165817),  q30_of(64'sd110081262225)};

   function automatic q30_type clamp_q30(input logic signed [VW-1:0] v);
      if (v > ONE_V) begin
         return ONE_Q;
      end else if (v < -ONE_V) begin
         return -ONE_Q;
      end
      return 32'(v);
   endfunction

   // Round half up of v / 2^30, back to a vector component.
   function automatic logic signed [VW-1:0] round_q30(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] t;
      t = (v + ROUND_BIAS) >>> VEC_FRAC;
      return VW'(t);
   endfunction

endpackage

@@ rtl/sky_frame_rotation.sv @@
// Items pass the input stage, rotation rows, matrix, vectoring rows and output register.
// Throughput: one position per cycle; a result waiting at the output stalls the row
// only once the last CORDIC cell also holds a finished item.
// Reset: synchronous, active high; clears every valid bit, payload registers are not reset.
// The block keeps no state between items.
module sky_frame_rotation (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_opcode,
   input  logic [31:0]               req_in_lon,
   input  logic signed [31:0]        req_in_lat,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [31:0]               rsp_out_lon,
   output logic signed [31:0]        rsp_out_lat
);
   import sfr_pkg::*;

   // The whole row moves together. It only holds when the last cell has a
   // finished item and the output register is still waiting on its transfer.
   logic en;

   // Input stage: wrap and reduce the longitude into a quarter turn of zero,
   // clamp the latitude to the poles.
   logic signed [AW-1:0] lon_w;
   logic signed [AW-1:0] lat_w;
   logic signed [AW-1:0] lon_in;
   logic signed [AW-1:0] lat_in;
   logic                 flip_in;
   logic                 s0_valid_ff;
   logic signed [AW-1:0] s0_lon_ff;
   logic signed [AW-1:0] s0_lat_ff;
   logic                 s0_flip_ff;
   logic [1:0]           s0_op_ff;

   always_comb begin
      lon_w = AW'(signed'(req_in_lon));
      lat_w = AW'(req_in_lat);
      lon_in = lon_w;
      flip_in = 1'b0;
      if (lon_w > QUARTER) begin
         lon_in = lon_w - HALF;
         flip_in = 1'b1;
      end else if (lon_w < -QUARTER) begin
         lon_in = lon_w + HALF;
         flip_in = 1'b1;
      end
      lat_in = lat_w;
      if (lat_w > QUARTER) begin
         lat_in = QUARTER;
      end else if (lat_w < -QUARTER) begin
         lat_in = -QUARTER;
      end
   end

   // Rotation row: two CORDIC rows side by side give the cosine and sine of
   // latitude and of longitude. Opcode and the half-turn flag ride alongside.
   cordic_type lat_d [ROT_STEPS+1];
   cordic_type lon_d [ROT_STEPS+1];
   logic       lat_v [ROT_STEPS+1];
   logic       lon_v [ROT_STEPS+1];
   logic [1:0] rop_ff [ROT_STEPS];
   logic       rflip_ff [ROT_STEPS];

   assign lat_d[0] = '{x: GAIN, y: '0, z: s0_lat_ff};
   assign lon_d[0] = '{x: GAIN, y: '0, z: s0_lon_ff};
   assign lat_v[0] = s0_valid_ff;
   assign lon_v[0] = s0_valid_ff;

   for (genvar i = 0; i < ROT_STEPS; i++) begin : g_rot
      sfr_cordic_cell u_lat (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .vectoring (1'b0),
         .step      (STEP_W'(i)),
         .in_valid  (lat_v[i]),
         .in_data   (lat_d[i]),
         .out_valid (lat_v[i+1]),
         .out_data  (lat_d[i+1])
      );
      sfr_cordic_cell u_lon (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .vectoring (1'b0),
         .step      (STEP_W'(i)),
         .in_valid  (lon_v[i]),
         .in_data   (lon_d[i]),
         .out_valid (lon_v[i+1]),
         .out_data  (lon_d[i+1])
      );
   end

   // Cosines and sines are clamped to one, and the longitude pair is negated
   // when the input was reduced by half a turn.
   logic                 s1_valid_ff;
   q30_type              s1_cb_ff;
   q30_type              s1_sb_ff;
   q30_type              s1_cl_ff;
   q30_type              s1_sl_ff;
   logic [1:0]           s1_op_ff;
   logic                 s2_valid_ff;
   logic signed [PW-1:0] s2_p0_ff;
   logic signed [PW-1:0] s2_p1_ff;
   q30_type              s2_sb_ff;
   logic [1:0]           s2_op_ff;
   logic                 s3_valid_ff;
   q30_type              s3_u_ff [3];
   logic [1:0]           s3_op_ff;

   // Matrix product of the unit vector.
   logic    m_valid;
   q30_type m_w [3];

   sfr_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .op        (s3_op_ff),
      .in_u      (s3_u_ff),
      .out_valid (m_valid),
      .out_w     (m_w)
   );

   // Pole check and folding of the left half plane into x >= 0.
   logic                 s6_valid_ff;
   logic signed [VW-1:0] s6_x_ff;
   logic signed [VW-1:0] s6_y_ff;
   q30_type              s6_z_ff;
   logic                 s6_base_ff;
   logic                 s6_nzl_ff;

   // First vectoring row: longitude and the length of the xy projection.
   cordic_type va_d [ROT_STEPS+1];
   logic       va_v [ROT_STEPS+1];
   q30_type    vz_ff [ROT_STEPS];
   logic       vbase_ff [ROT_STEPS];
   logic       vnzl_ff [ROT_STEPS];

   assign va_d[0] = '{x: s6_x_ff, y: s6_y_ff, z: '0};
   assign va_v[0] = s6_valid_ff;

   for (genvar i = 0; i < ROT_STEPS; i++) begin : g_vec_a
      sfr_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .vectoring (1'b1),
         .step      (STEP_W'(i)),
         .in_valid  (va_v[i]),
         .in_data   (va_d[i]),
         .out_valid (va_v[i+1]),
         .out_data  (va_d[i+1])
      );
   end

   // Longitude is final here; the magnitude has the CORDIC gain removed.
   logic                 s7_valid_ff;
   logic [31:0]          s7_lon_ff;
   logic signed [MW-1:0] s7_prod_ff;
   q30_type              s7_z_ff;
   logic signed [AW-1:0] lon_sum;
   logic signed [MW-1:0] rad_t;
   logic signed [VW-1:0] rad;
   logic                 s8_valid_ff;
   logic [31:0]          s8_lon_ff;
   logic signed [VW-1:0] s8_rad_ff;
   q30_type              s8_z_ff;
   logic                 s8_nzz_ff;

   assign lon_sum = (vbase_ff[ROT_STEPS-1] ? HALF : '0) + va_d[ROT_STEPS].z;
   assign rad_t = (s7_prod_ff + MW'(ROUND_BIAS)) >>> VEC_FRAC;
   assign rad = VW'(rad_t);

   // Second vectoring row: latitude as atan2(z, radius).
   cordic_type vb_d [ROT_STEPS+1];
   logic       vb_v [ROT_STEPS+1];
   logic [31:0] wlon_ff [ROT_STEPS];
   logic       wnzz_ff [ROT_STEPS];

   assign vb_d[0] = '{x: s8_rad_ff, y: VW'(s8_z_ff), z: '0};
   assign vb_v[0] = s8_valid_ff;

   for (genvar i = 0; i < ROT_STEPS; i++) begin : g_vec_b
      sfr_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .vectoring (1'b1),
         .step      (STEP_W'(i)),
         .in_valid  (vb_v[i]),
         .in_data   (vb_d[i]),
         .out_valid (vb_v[i+1]),
         .out_data  (vb_d[i+1])
      );
   end

   // Output register with its own valid, loaded whenever it is empty or its
   // transfer completes.
   logic                 rsp_valid_ff;
   logic [31:0]          rsp_lon_ff;
   logic signed [31:0]   rsp_lat_ff;
   logic signed [AW-1:0] lat_ang;
   logic signed [31:0]   lat_out;

   always_comb begin
      lat_ang = vb_d[ROT_STEPS].z;
      if (!wnzz_ff[ROT_STEPS-1]) begin
         lat_out = '0;
      end else if (lat_ang > QUARTER) begin
         lat_out = 32'(QUARTER);
      end else if (lat_ang < -QUARTER) begin
         lat_out = 32'(-QUARTER);
      end else begin
         lat_out = 32'(lat_ang);
      end
   end

   assign en = !(vb_v[ROT_STEPS] && rsp_valid_ff && !rsp_ready);
   assign req_ready = en;

   // Valid bits of the stages outside the cells.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
         s1_valid_ff <= lat_v[ROT_STEPS] && lon_v[ROT_STEPS];
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s6_valid_ff <= m_valid;
         s7_valid_ff <= va_v[ROT_STEPS];
         s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff <= vb_v[ROT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_ready) begin
         rsp_lon_ff <= wlon_ff[ROT_STEPS-1];
         rsp_lat_ff <= lat_out;
      end
   end

   // Payload of the pipeline stages and the side lines beside the rows.
   always_ff @(posedge clock) begin
      if (en) begin
         s0_lon_ff <= lon_in;
         s0_lat_ff <= lat_in;
         s0_flip_ff <= flip_in;
         s0_op_ff <= req_opcode;

         rop_ff[0] <= s0_op_ff;
         rflip_ff[0] <= s0_flip_ff;
         for (int i = 1; i < ROT_STEPS; i++) begin
            rop_ff[i] <= rop_ff[i-1];
            rflip_ff[i] <= rflip_ff[i-1];
         end

         s1_cb_ff <= clamp_q30(lat_d[ROT_STEPS].x);
         s1_sb_ff <= clamp_q30(lat_d[ROT_STEPS].y);
         s1_cl_ff <= rflip_ff[ROT_STEPS-1] ? -clamp_q30(lon_d[ROT_STEPS].x)
                                            : clamp_q30(lon_d[ROT_STEPS].x);
         s1_sl_ff <= rflip_ff[ROT_STEPS-1] ? -clamp_q30(lon_d[ROT_STEPS].y)
                                            : clamp_q30(lon_d[ROT_STEPS].y);
         s1_op_ff <= rop_ff[ROT_STEPS-1];

         s2_p0_ff <= s1_cb_ff * s1_cl_ff;
         s2_p1_ff <= s1_cb_ff * s1_sl_ff;
         s2_sb_ff <= s1_sb_ff;
         s2_op_ff <= s1_op_ff;

         s3_u_ff[0] <= 32'(round_q30(SW'(s2_p0_ff)));
         s3_u_ff[1] <= 32'(round_q30(SW'(s2_p1_ff)));
         s3_u_ff[2] <= s2_sb_ff;
         s3_op_ff <= s2_op_ff;

         s6_nzl_ff <= (m_w[0] != 0) || (m_w[1] != 0);
         s6_base_ff <= m_w[0] < 0;
         s6_x_ff <= (m_w[0] < 0) ? -VW'(m_w[0]) : VW'(m_w[0]);
         s6_y_ff <= (m_w[0] < 0) ? -VW'(m_w[1]) : VW'(m_w[1]);
         s6_z_ff <= m_w[2];

         vz_ff[0] <= s6_z_ff;
         vbase_ff[0] <= s6_base_ff;
         vnzl_ff[0] <= s6_nzl_ff;
         for (int i = 1; i < ROT_STEPS; i++) begin
            vz_ff[i] <= vz_ff[i-1];
            vbase_ff[i] <= vbase_ff[i-1];
            vnzl_ff[i] <= vnzl_ff[i-1];
         end

         s7_lon_ff <= vnzl_ff[ROT_STEPS-1] ? lon_sum[31:0] : '0;
         s7_prod_ff <= vnzl_ff[ROT_STEPS-1] ? va_d[ROT_STEPS].x * GAIN : '0;
         s7_z_ff <= vz_ff[ROT_STEPS-1];

         s8_lon_ff <= s7_lon_ff;
         s8_rad_ff <= rad;
         s8_z_ff <= s7_z_ff;
         s8_nzz_ff <= (rad != 0) || (s7_z_ff != 0);

         wlon_ff[0] <= s8_lon_ff;
         wnzz_ff[0] <= s8_nzz_ff;
         for (int i = 1; i < ROT_STEPS; i++) begin
            wlon_ff[i] <= wlon_ff[i-1];
            wnzz_ff[i] <= wnzz_ff[i-1];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_lon = rsp_lon_ff;
   assign rsp_out_lat = rsp_lat_ff;

   // A finished item in the last cell must not be lost while the output waits.
   a_last_held: assert property (@(posedge clock) disable iff (reset)
      (vb_v[ROT_STEPS] && rsp_valid_ff && !rsp_ready) |=> vb_v[ROT_STEPS])
      else $error("last cell dropped an item during an output stall");

   // Latitude never leaves the poles.
   a_lat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_lat_ff <= 32'sd1073741824 && rsp_lat_ff >= -32'sd1073741824))
      else $error("output latitude beyond a quarter turn");

   // The folded vector always enters the vectoring row with x >= 0.
   a_fold: assert property (@(posedge clock) disable iff (reset)
      s6_valid_ff |-> (s6_x_ff >= 0))
      else $error("vectoring input has negative x");

   // The rotated z component stays clamped to one.
   a_mat_range: assert property (@(posedge clock) disable iff (reset)
      m_valid |-> (m_w[2] <= ONE_Q && m_w[2] >= -ONE_Q))
      else $error("matrix output beyond one");

endmodule

@@ rtl/sfr_cordic_cell.sv @@
module sfr_cordic_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         vectoring,
   input  logic [sfr_pkg::STEP_W-1:0]   step,
   input  logic                         in_valid,
   input  sfr_pkg::cordic_type          in_data,
   output logic                         out_valid,
   output sfr_pkg::cordic_type          out_data
);
   import sfr_pkg::*;

   logic                 valid_ff;
   cordic_type           data_ff;
   cordic_type           data_in;
   logic signed [VW-1:0] dx;
   logic signed [VW-1:0] dy;
   logic                 turn_pos;

   // Rotation drives z toward zero; vectoring drives y toward zero.
   always_comb begin
      dx = in_data.y >>> step;
      dy = in_data.x >>> step;
      turn_pos = vectoring ? (in_data.y < 0) : (in_data.z >= 0);
      if (turn_pos) begin
         data_in.x = in_data.x - dx;
         data_in.y = in_data.y + dy;
         data_in.z = in_data.z - ARC_TAB[step];
      end else begin
         data_in.x = in_data.x + dx;
         data_in.y = in_data.y - dy;
         data_in.z = in_data.z + ARC_TAB[step];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

@@ rtl/sfr_matrix.sv @@
module sfr_matrix (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [1:0]        op,
   input  sfr_pkg::q30_type  in_u [3],
   output logic              out_valid,
   output sfr_pkg::q30_type  out_w [3]
);
   import sfr_pkg::*;

   logic                 fwd;
   logic                 sel;
   q30_type              coef [3][3];
   logic signed [PW-1:0] prod_ff [3][3];
   logic                 prod_valid_ff;
   logic                 w_valid_ff;
   q30_type              w_ff [3];
   logic signed [SW-1:0] acc [3];

   // Inverse directions use the transpose of the stored matrix.
   always_comb begin
      fwd = (op == OP_EQ_TO_GAL) || (op == OP_GAL_TO_SG);
      sel = (op == OP_GAL_TO_SG) || (op == OP_SG_TO_GAL);
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            coef[r][k] = FRAME_Q[(sel ? 5'd9 : 5'd0)
                                 + (fwd ? 5'(r * 3 + k) : 5'(k * 3 + r))];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r] = SW'(prod_ff[r][0]) + SW'(prod_ff[r][1]) + SW'(prod_ff[r][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         w_valid_ff <= 1'b0;
      end else if (en) begin
         prod_valid_ff <= in_valid;
         w_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               prod_ff[r][k] <= coef[r][k] * in_u[k];
            end
            w_ff[r] <= clamp_q30(round_q30(acc[r]));
         end
      end
   end

   assign out_valid = w_valid_ff;
   assign out_w = w_ff;

endmodule

@@ tb/sky_frame_checker.sv @@
module sky_frame_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic [31:0]        req_in_lon,
   input  logic signed [31:0] req_in_lat,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [31:0]        rsp_out_lon,
   input  logic signed [31:0] rsp_out_lat,
   output int                 errors,
   output int                 pending
);

   timeunit 1ns;
   timeprecision 1ps;

   import sfr_pkg::*;

   typedef struct {
      logic [31:0]        lon;
      logic signed [31:0] lat;
   } sky_pos_type;

   localparam longint QTURN = 64'sd1 << 30;
   localparam longint HTURN = 64'sd1 << 31;
   localparam longint UNIT = 64'sd1 << 30;
   localparam longint CGAIN = 64'sd652032874;
   localparam longint HALF_LSB = 64'sd1 << 29;

   // Rotation coefficients in units of 1e-12, row-major.
   localparam longint COEF_E12 [18] = '{
      -64'sd54875539726, -64'sd873437108010, -64'sd483834985808,
      64'sd494109453312, -64'sd444829589425, 64'sd746982251810,
      -64'sd867666135858, -64'sd198076386122, 64'sd455983795705,
      -64'sd735742574804, 64'sd677261296414, 64'sd0,
      -64'sd74553778365, -64'sd80991471307, 64'sd993922590400,
      64'sd673145302109, 64'sd731271165817, 64'sd110081262225};

   longint      arc_step [30];
   longint      rot_coef [18];
   sky_pos_type expected_pos [$];

   function automatic longint unsigned atan_of_recip(input longint unsigned n);
      longint unsigned p, plus, minus, n2, k;
      p = (64'd1 << 60) / n;
      plus = p;
      minus = 0;
      n2 = n * n;
      k = 1;
      while (1) begin
         p = p / n2;
         if (p == 0) break;
         if (k[0]) minus += p / (2 * k + 1);
         else plus += p / (2 * k + 1);
         k++;
      end
      return plus - minus;
   endfunction

   function automatic longint unsigned atan_of_pow2(input int i);
      longint unsigned plus, minus, t;
      int k;
      plus = 0;
      minus = 0;
      for (k = 0; i * (2 * k + 1) <= 60; k++) begin
         t = (64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1);
         if (k % 2 == 1) minus += t;
         else plus += t;
      end
      return plus - minus;
   endfunction

   initial begin
      longint unsigned full_turn, r, q, mag;
      full_turn = 2 * (16 * atan_of_recip(5) - 4 * atan_of_recip(239));
      arc_step[0] = 64'sd1 << 29;
      for (int i = 1; i < 30; i++) begin
         r = atan_of_pow2(i);
         q = 0;
         for (int b = 0; b < 33; b++) begin
            r = r << 1;
            q = q << 1;
            if (r >= full_turn) begin
               r -= full_turn;
               q |= 1;
            end
         end
         arc_step[i] = longint'((q + 1) >> 1);
      end
      for (int i = 0; i < 18; i++) begin
         mag = (COEF_E12[i] < 0) ? -COEF_E12[i] : COEF_E12[i];
         q = (mag * 262144 + 122070312) / 244140625;
         rot_coef[i] = (COEF_E12[i] < 0) ? -longint'(q) : longint'(q);
      end
   end

   function automatic longint clip(input longint v, input longint lim);
      return (v > lim) ? lim : ((v < -lim) ? -lim : v);
   endfunction

   function automatic longint round_q30(input longint v);
      return (v + HALF_LSB) >>> 30;
   endfunction

   task automatic sin_cos(input longint ang, output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = CGAIN;
      y = 0;
      z = ang;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arc_step[i];
         end else begin
            x += dx; y -= dy; z += arc_step[i];
         end
      end
      c = clip(x, UNIT);
      s = clip(y, UNIT);
   endtask

   task automatic arc_tan2(input longint x0, input longint y0, output longint ang,
                           output longint mag);
      longint x, y, dx, dy;
      x = x0;
      y = y0;
      ang = 0;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; ang += arc_step[i];
         end else begin
            x -= dx; y += dy; ang -= arc_step[i];
         end
      end
      mag = x;
   endtask

   task automatic convert_position(input logic [1:0] op, input logic [31:0] in_lon,
                                   input logic signed [31:0] in_lat,
                                   output sky_pos_type res);
      bit     forward, flip;
      int     base_idx;
      longint lon, lat, cb, sb, cl, sl, acc, x, y, z, ang, mag, rad, offset;
      longint u [3];
      longint w [3];
      forward = (op == OP_EQ_TO_GAL) || (op == OP_GAL_TO_SG);
      base_idx = ((op == OP_GAL_TO_SG) || (op == OP_SG_TO_GAL)) ? 9 : 0;
      flip = 0;
      lon = longint'($signed(in_lon));
      // Fold far longitudes by half a turn so CORDIC stays in range.
      if (lon > QTURN) begin
         lon -= HTURN; flip = 1;
      end else if (lon < -QTURN) begin
         lon += HTURN; flip = 1;
      end
      lat = clip(longint'(in_lat), QTURN);
      sin_cos(lat, cb, sb);
      sin_cos(lon, cl, sl);
      if (flip) begin
         cl = -cl; sl = -sl;
      end
      u[0] = round_q30(cb * cl);
      u[1] = round_q30(cb * sl);
      u[2] = sb;
      for (int r = 0; r < 3; r++) begin
         acc = 0;
         for (int k = 0; k < 3; k++)
            acc += rot_coef[base_idx + (forward ? r * 3 + k : k * 3 + r)] * u[k];
         w[r] = clip(round_q30(acc), UNIT);
      end
      x = w[0]; y = w[1]; z = w[2];
      res.lon = '0;
      res.lat = '0;
      rad = 0;
      if (x != 0 || y != 0) begin
         offset = 0;
         if (x < 0) begin
            x = -x; y = -y; offset = HTURN;
         end
         arc_tan2(x, y, ang, mag);
         res.lon = 32'(offset + ang);
         rad = round_q30(mag * CGAIN);
      end
      if (rad != 0 || z != 0) begin
         arc_tan2(rad, z, ang, mag);
         res.lat = 32'(clip(ang, QTURN));
      end
   endtask

   task automatic report(input string what);
      $display("%0t: mismatch: %s", $realtime, what);
      errors++;
   endtask

   initial begin
      errors = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      sky_pos_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            convert_position(req_opcode, req_in_lon, req_in_lat, want);
            expected_pos.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pos.size() == 0) begin
               report("result transfer with nothing expected");
            end else begin
               want = expected_pos.pop_front();
               if (rsp_out_lon !== want.lon)
                  report($sformatf("out_lon %h, expected %h", rsp_out_lon, want.lon));
               if (rsp_out_lat !== want.lat)
                  report($sformatf("out_lat %h, expected %h", rsp_out_lat, want.lat));
            end
         end
         pending = expected_pos.size();
      end
   end

endmodule

@@ tb/sky_frame_rotation_test.sv @@
module sky_frame_rotation_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sfr_pkg::*;

   // Generous bound: every item could see the longest gap and longest stall.
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 500;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_opcode;
   logic [31:0]        req_in_lon;
   logic signed [31:0] req_in_lat;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [31:0]        rsp_out_lon;
   logic signed [31:0] rsp_out_lat;
   int                 errors;
   int                 pending;
   int                 cycles;
   int                 stall_left;
   bit                 steady;

   sky_frame_rotation dut (.*);

   sky_frame_checker checker_i (.*);

   initial clock = 0;
   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_opcode = OP_EQ_TO_GAL;
      req_in_lon = '0;
      req_in_lat = '0;
      rsp_ready = 0;
      stall_left = 0;
      steady = 0;
      cycles = 0;
   end

   // The timeout counts every cycle from the start of the run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // The receiver draws a fresh stall after each result transfer. While the
   // steady flag is set it never stalls, so back-to-back transfers occur.
   always @(posedge clock) begin
      int w;
      if (reset) begin
         rsp_ready <= 0;
         stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         w = steady ? 0 : $urandom_range(0, 11);
         stall_left <= w;
         rsp_ready <= (w == 0);
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= 0;
         rsp_ready <= 1;
      end
   end

   // Sends one position. A gap lowers valid first; with no gap the new
   // payload follows the previous transfer on the very next edge.
   task automatic send_position(input logic [1:0] op, input logic [31:0] lon,
                                input logic [31:0] lat);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_opcode <= op;
      req_in_lon <= lon;
      req_in_lat <= lat;
      // Ready is checked between edges, where every signal has settled.
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   logic [1:0]  ops [4] = '{OP_EQ_TO_GAL, OP_GAL_TO_EQ, OP_GAL_TO_SG, OP_SG_TO_GAL};
   logic [31:0] lon_edges [6] = '{32'h0000_0000, 32'h4000_0000, 32'h4000_0001,
                                  32'hBFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
   logic [31:0] lat_edges [6] = '{32'h4000_0000, 32'hC000_0000, 32'h7FFF_FFFF,
                                  32'h8000_0000, 32'h0000_0000, 32'h3FFF_FFFF};

   initial begin
      logic [31:0] lat;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: every conversion against the longitude fold limits,
      // the poles, latitudes beyond a quarter turn and all-ones words.
      for (int i = 0; i < 24; i++)
         send_position(ops[i % 4], lon_edges[i % 6], lat_edges[(i / 4 + i) % 6]);

      // Let the pipeline drain completely before the random part.
      req_valid <= 0;
      wait (pending == 0);
      @(posedge clock);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // Alternate stretches with and without idling on both sides.
         if (n % 100 == 0) steady = bit'((n / 100) % 2);
         if (n == RANDOM_ITEMS / 2) begin
            req_valid <= 0;
            wait (pending == 0);
            @(posedge clock);
         end
         // Mostly legal latitudes; the rest exercise saturation.
         if ($urandom_range(0, 7) == 0) lat = $urandom;
         else lat = 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
         send_position(2'($urandom_range(0, 3)), $urandom, lat);
      end
      req_valid <= 0;
      steady = 0;

      wait (pending == 0);
      repeat (120) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
